// ===== rtl/point_segment_distance_top_macros.svh =====
// ---------------------------------------------------------------------------
// point_segment_distance_top_macros
// assertion macros for the point to segment distance block
// ---------------------------------------------------------------------------
`ifndef POINT_SEGMENT_DISTANCE_TOP_MACROS_SVH
`define POINT_SEGMENT_DISTANCE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define PSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PSD_ASSERT_NOW(label, clk, rst, ante, cons, msg)

`define PSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/psd_pkg.sv =====
// ---------------------------------------------------------------------------
// psd_pkg
// shared constants for the point to segment distance pipeline
// ---------------------------------------------------------------------------
package psd_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FIELD_W        = 32;
  localparam int DIST_W         = 32;
  localparam int LIMIT_W        = 17;
  localparam int FRAC_W         = 32;
  localparam int QUO_W          = FRAC_W + 1;
  localparam int LANES          = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd1;
  localparam logic [63:0]        ROUND_HALF  = 64'h0000_0000_8000_0000;

  localparam logic [1:0] KIND_3D = 2'd0;
  localparam logic [1:0] KIND_XY = 2'd1;
  localparam logic [1:0] KIND_YZ = 2'd2;
  localparam logic [1:0] KIND_ZX = 2'd3;

  localparam logic [1:0] REGION_INTERIOR = 2'd0;
  localparam logic [1:0] REGION_BEFORE   = 2'd1;
  localparam logic [1:0] REGION_PAST     = 2'd2;
  localparam logic [1:0] REGION_DEGEN    = 2'd3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // axis used by each lane, indexed by kind
  localparam logic [1:0] AXIS_OF [4][LANES] = '{
    '{AXIS_X, AXIS_Y, AXIS_Z},
    '{AXIS_X, AXIS_Y, AXIS_X},
    '{AXIS_Y, AXIS_Z, AXIS_X},
    '{AXIS_Z, AXIS_X, AXIS_X}
  };

endpackage

// ===== rtl/psd_div.sv =====
// ---------------------------------------------------------------------------
// psd_div
// pipelined restoring divider, one quotient bit per stage, num <= den
// ---------------------------------------------------------------------------
module psd_div import psd_pkg::*; #(
  parameter int DW = 2 * COORD_BITS_DEF + 2,
  parameter int QW = QUO_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem [QW];
  logic [DW-1:0] dn  [QW];
  logic [QW-1:0] qt  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] rin;
    logic [DW:0] dext;
    logic        take;
    logic [DW:0] rsub;

    if (k == 0) begin : g_first
      assign rin  = {1'b0, num};
      assign dext = {1'b0, den};
    end else begin : g_next
      assign rin  = {rem[k-1], 1'b0};
      assign dext = {1'b0, dn[k-1]};
    end

    assign take = (rin >= dext);
    assign rsub = rin - dext;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? rsub[DW-1:0] : rin[DW-1:0];
        if (k == 0) begin
          dn[k] <= den;
          qt[k] <= {{(QW-1){1'b0}}, take};
        end else begin
          dn[k] <= dn[k-1];
          qt[k] <= {qt[k-1][QW-2:0], take};
        end
      end
    end
  end

  assign quo = qt[QW-1];

endmodule

// ===== rtl/psd_sqrt.sv =====
// ---------------------------------------------------------------------------
// psd_sqrt
// pipelined floor square root, one result bit per stage
// ---------------------------------------------------------------------------
module psd_sqrt import psd_pkg::*; #(
  parameter int NW = 2 * COORD_BITS_DEF + 6,
  parameter int RW = NW / 2
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] rad,
  output logic [RW-1:0] root
);

  logic [RW+1:0] rem [RW];
  logic [RW-1:0] res [RW];
  logic [NW-1:0] opd [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+1:0] rsh;
    logic [RW+1:0] trial;
    logic          take;
    logic [NW-1:0] src;

    if (k == 0) begin : g_first
      assign src   = rad;
      assign rsh   = {{RW{1'b0}}, rad[NW-1 -: 2]};
      assign trial = {{RW{1'b0}}, 2'b01};
    end else begin : g_next
      assign src   = opd[k-1];
      assign rsh   = {rem[k-1][RW-1:0], opd[k-1][NW-1 -: 2]};
      assign trial = {res[k-1], 2'b01};
    end

    assign take = (rsh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? (rsh - trial) : rsh;
        opd[k] <= {src[NW-3:0], 2'b00};
        if (k == 0) begin
          res[k] <= {{(RW-1){1'b0}}, take};
        end else begin
          res[k] <= {res[k-1][RW-2:0], take};
        end
      end
    end
  end

  assign root = res[RW-1];

endmodule

// ===== rtl/point_segment_distance_top.sv =====
// throughput: one item per cycle while not stalled; 33 divider stages and COORD_BITS + 3 root stages
// the whole pipeline holds while a finished result is stalled at the output
// reset: synchronous, clears all valid bits and loads the limit register with 1
// ---------------------------------------------------------------------------
// point_segment_distance_top
// distance from a point to a segment in 3d or a plane projection, q16.16
// ---------------------------------------------------------------------------
`include "point_segment_distance_top_macros.svh"

module point_segment_distance_top import psd_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [LIMIT_W-1:0]        zero_length_limit,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                kind,
  input  logic signed [FIELD_W-1:0] point_x,
  input  logic signed [FIELD_W-1:0] point_y,
  input  logic signed [FIELD_W-1:0] point_z,
  input  logic signed [FIELD_W-1:0] first_x,
  input  logic signed [FIELD_W-1:0] first_y,
  input  logic signed [FIELD_W-1:0] first_z,
  input  logic signed [FIELD_W-1:0] second_x,
  input  logic signed [FIELD_W-1:0] second_y,
  input  logic signed [FIELD_W-1:0] second_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [DIST_W-1:0]         distance,
  output logic [1:0]                region
);

  localparam int CW    = COORD_BITS;
  localparam int P_W   = 2 * CW;
  localparam int S_W   = 2 * CW + 2;
  localparam int E_W   = CW + 2;
  localparam int PR_W  = QUO_W + CW + 1;
  localparam int RN_W  = 2 * E_W + 2;
  localparam int RT_W  = RN_W / 2;
  localparam int SAT_W = RT_W + DIST_W;
  localparam int L2_W  = 2 * LIMIT_W;

  typedef struct packed {
    logic [1:0]                region;
    logic [S_W-1:0]            alt;
    logic [LANES-1:0][CW-1:0]  am;
    logic [LANES-1:0][CW-1:0]  bm;
    logic [LANES-1:0]          xs;
  } dside_t;

  function automatic logic [CW:0] cdiff(input logic [CW-1:0] u, input logic [CW-1:0] v);
    logic [CW-1:0] bu;
    logic [CW-1:0] bv;
    bu = u ^ {1'b1, {(CW-1){1'b0}}};
    bv = v ^ {1'b1, {(CW-1){1'b0}}};
    if (bu >= bv) begin
      cdiff = {1'b0, bu - bv};
    end else begin
      cdiff = {1'b1, bv - bu};
    end
  endfunction

  logic en;
  logic [LIMIT_W-1:0] limit;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign en        = ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= zero_length_limit;
    end
  end

  // stage a: axis select and differences
  logic [CW-1:0] pc [3];
  logic [CW-1:0] fc [3];
  logic [CW-1:0] sc [3];

  assign pc[0] = CW'($unsigned(point_x));
  assign pc[1] = CW'($unsigned(point_y));
  assign pc[2] = CW'($unsigned(point_z));
  assign fc[0] = CW'($unsigned(first_x));
  assign fc[1] = CW'($unsigned(first_y));
  assign fc[2] = CW'($unsigned(first_z));
  assign sc[0] = CW'($unsigned(second_x));
  assign sc[1] = CW'($unsigned(second_y));
  assign sc[2] = CW'($unsigned(second_z));

  logic                  va;
  logic [CW-1:0]         a_am [LANES];
  logic [CW-1:0]         a_bm [LANES];
  logic [CW-1:0]         a_cm [LANES];
  logic [LANES-1:0]      a_xs;

  for (genvar i = 0; i < LANES; i++) begin : g_lane_a
    logic [1:0]  ax;
    logic        on;
    logic [CW:0] da;
    logic [CW:0] db;
    logic [CW:0] dc;

    assign ax = AXIS_OF[kind][i];
    assign on = (i < 2) || (kind == KIND_3D);
    assign da = cdiff(pc[ax], fc[ax]);
    assign db = cdiff(sc[ax], fc[ax]);
    assign dc = cdiff(pc[ax], sc[ax]);

    always_ff @(posedge clk) begin
      if (en) begin
        a_am[i] <= on ? da[CW-1:0] : '0;
        a_bm[i] <= on ? db[CW-1:0] : '0;
        a_cm[i] <= on ? dc[CW-1:0] : '0;
        a_xs[i] <= da[CW] ^ db[CW];
      end
    end
  end

  // stage b: products
  logic                  vb;
  logic [P_W-1:0]        b_bb [LANES];
  logic [P_W-1:0]        b_ab [LANES];
  logic [P_W-1:0]        b_aa [LANES];
  logic [P_W-1:0]        b_cc [LANES];
  logic [CW-1:0]         b_am [LANES];
  logic [CW-1:0]         b_bm [LANES];
  logic [LANES-1:0]      b_xs;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        b_bb[i] <= P_W'(a_bm[i]) * P_W'(a_bm[i]);
        b_ab[i] <= P_W'(a_am[i]) * P_W'(a_bm[i]);
        b_aa[i] <= P_W'(a_am[i]) * P_W'(a_am[i]);
        b_cc[i] <= P_W'(a_cm[i]) * P_W'(a_cm[i]);
        b_am[i] <= a_am[i];
        b_bm[i] <= a_bm[i];
      end
      b_xs <= a_xs;
    end
  end

  // stage c: sums and limit square
  logic                  vc;
  logic [S_W-1:0]        c_len2;
  logic [S_W-1:0]        c_pos;
  logic [S_W-1:0]        c_neg;
  logic [S_W-1:0]        c_sa;
  logic [S_W-1:0]        c_sc;
  logic [L2_W-1:0]       c_lim2;
  logic [CW-1:0]         c_am [LANES];
  logic [CW-1:0]         c_bm [LANES];
  logic [LANES-1:0]      c_xs;

  logic [S_W-1:0] len2_next;
  logic [S_W-1:0] pos_next;
  logic [S_W-1:0] neg_next;
  logic [S_W-1:0] sa_next;
  logic [S_W-1:0] sc_next;

  always_comb begin
    len2_next = '0;
    pos_next  = '0;
    neg_next  = '0;
    sa_next   = '0;
    sc_next   = '0;
    for (int i = 0; i < LANES; i++) begin
      len2_next = len2_next + S_W'(b_bb[i]);
      sa_next   = sa_next + S_W'(b_aa[i]);
      sc_next   = sc_next + S_W'(b_cc[i]);
      if (b_xs[i]) begin
        neg_next = neg_next + S_W'(b_ab[i]);
      end else begin
        pos_next = pos_next + S_W'(b_ab[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_len2 <= len2_next;
      c_pos  <= pos_next;
      c_neg  <= neg_next;
      c_sa   <= sa_next;
      c_sc   <= sc_next;
      c_lim2 <= L2_W'(limit) * L2_W'(limit);
      for (int i = 0; i < LANES; i++) begin
        c_am[i] <= b_am[i];
        c_bm[i] <= b_bm[i];
      end
      c_xs <= b_xs;
    end
  end

  // stage d: region decision
  logic           vd;
  logic [S_W-1:0] d_num;
  logic [S_W-1:0] d_len2;
  dside_t         d_side;

  logic [S_W-1:0] dm;
  logic [1:0]     reg_next;
  logic [S_W-1:0] alt_next;

  assign dm = c_pos - c_neg;

  always_comb begin
    if ((c_len2 == '0) || (c_len2 < S_W'(c_lim2))) begin
      reg_next = REGION_DEGEN;
      alt_next = c_sa;
    end else if (c_neg > c_pos) begin
      reg_next = REGION_BEFORE;
      alt_next = c_sa;
    end else if (dm > c_len2) begin
      reg_next = REGION_PAST;
      alt_next = c_sc;
    end else begin
      reg_next = REGION_INTERIOR;
      alt_next = c_sa;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_num         <= (reg_next == REGION_INTERIOR) ? dm : '0;
      d_len2        <= c_len2;
      d_side.region <= reg_next;
      d_side.alt    <= alt_next;
      for (int i = 0; i < LANES; i++) begin
        d_side.am[i] <= c_am[i];
        d_side.bm[i] <= c_bm[i];
      end
      d_side.xs <= c_xs;
    end
  end

  // divider and its side pipe
  logic [QUO_W-1:0] quo;
  logic [QUO_W-1:0] dval;
  dside_t           dpipe [QUO_W];

  psd_div #(.DW(S_W), .QW(QUO_W)) u_div (
    .clk (clk),
    .en  (en),
    .num (d_num),
    .den (d_len2),
    .quo (quo)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dpipe[0] <= d_side;
      for (int i = 1; i < QUO_W; i++) begin
        dpipe[i] <= dpipe[i-1];
      end
    end
  end

  // stage e: rounded offsets u * b
  logic             ve;
  logic [E_W-1:0]   e_off [LANES];
  logic [CW-1:0]    e_am  [LANES];
  logic [LANES-1:0] e_xs;
  logic [1:0]       e_region;
  logic [S_W-1:0]   e_alt;

  dside_t dlast;
  assign dlast = dpipe[QUO_W-1];

  for (genvar i = 0; i < LANES; i++) begin : g_lane_e
    logic [PR_W-1:0] prod;
    assign prod = PR_W'(quo) * PR_W'(dlast.bm[i]) + PR_W'(ROUND_HALF);

    always_ff @(posedge clk) begin
      if (en) begin
        e_off[i] <= prod[PR_W-1:FRAC_W];
        e_am[i]  <= dlast.am[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_xs     <= dlast.xs;
      e_region <= dlast.region;
      e_alt    <= dlast.alt;
    end
  end

  // stage f: residual components
  logic           vf;
  logic [E_W-1:0] f_em [LANES];
  logic [1:0]     f_region;
  logic [S_W-1:0] f_alt;

  for (genvar i = 0; i < LANES; i++) begin : g_lane_f
    logic [E_W-1:0] ae;
    assign ae = E_W'(e_am[i]);

    always_ff @(posedge clk) begin
      if (en) begin
        if (e_xs[i]) begin
          f_em[i] <= ae + e_off[i];
        end else if (ae >= e_off[i]) begin
          f_em[i] <= ae - e_off[i];
        end else begin
          f_em[i] <= e_off[i] - ae;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_region <= e_region;
      f_alt    <= e_alt;
    end
  end

  // stage g: squares
  logic             vg;
  logic [2*E_W-1:0] g_sq [LANES];
  logic [1:0]       g_region;
  logic [S_W-1:0]   g_alt;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        g_sq[i] <= (2*E_W)'(f_em[i]) * (2*E_W)'(f_em[i]);
      end
      g_region <= f_region;
      g_alt    <= f_alt;
    end
  end

  // stage h: radicand select
  logic            vh;
  logic [RN_W-1:0] h_rad;
  logic [1:0]      h_region;
  logic [RN_W-1:0] esum;

  always_comb begin
    esum = '0;
    for (int i = 0; i < LANES; i++) begin
      esum = esum + RN_W'(g_sq[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_rad    <= (g_region == REGION_INTERIOR) ? esum : RN_W'(g_alt);
      h_region <= g_region;
    end
  end

  // square root and its side pipe
  logic [RT_W-1:0]  root;
  logic [RT_W-1:0]  sval;
  logic [1:0]       spipe [RT_W];
  logic [SAT_W-1:0] rext;

  psd_sqrt #(.NW(RN_W), .RW(RT_W)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (h_rad),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      spipe[0] <= h_region;
      for (int i = 1; i < RT_W; i++) begin
        spipe[i] <= spipe[i-1];
      end
    end
  end

  assign rext = SAT_W'(root);

  always_ff @(posedge clk) begin
    if (en) begin
      distance <= (|rext[SAT_W-1:DIST_W]) ? {DIST_W{1'b1}} : rext[DIST_W-1:0];
      region   <= spipe[RT_W-1];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      dval      <= '0;
      ve        <= 1'b0;
      vf        <= 1'b0;
      vg        <= 1'b0;
      vh        <= 1'b0;
      sval      <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      va        <= in_valid;
      vb        <= va;
      vc        <= vb;
      vd        <= vc;
      dval      <= {dval[QUO_W-2:0], vd};
      ve        <= dval[QUO_W-1];
      vf        <= ve;
      vg        <= vf;
      vh        <= vg;
      sval      <= {sval[RT_W-2:0], vh};
      out_valid <= sval[RT_W-1];
    end
  end

  `PSD_ASSERT_NEXT(a_pipe_hold, clk, rst, in_stall, $stable(dval) && $stable(sval) && $stable(vd), "pipeline moved during stall")
  `PSD_ASSERT_NOW(a_quo_range, clk, rst, dval[QUO_W-1] && (dlast.region == REGION_INTERIOR), !quo[QUO_W-1] || (quo[QUO_W-2:0] == '0), "interior parameter above one")
  `PSD_ASSERT_NOW(a_out_region, clk, rst, out_valid && (region == REGION_INTERIOR), $past(en) || $stable(distance), "interior result changed while held")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for point_segment_distance_top. A directed table and
// random segment queries are pushed through the valid/stall input. A local
// fixed-point model predicts distance and region for untyped rows, and the
// output is checked in order. Random gaps, output stalls and one long output
// hold-off exercise backpressure. The limit register is swept between phases.
// ---------------------------------------------------------------------------
module tb;
  import psd_pkg::*;

  typedef struct {
    logic [1:0]                kind;
    logic signed [FIELD_W-1:0] pt [3];
    logic signed [FIELD_W-1:0] fa [3];
    logic signed [FIELD_W-1:0] sb [3];
  } query_t;

  typedef struct {
    logic [DIST_W-1:0] dist_raw;
    logic [1:0]        reg_code;
  } answer_t;

  typedef struct {
    query_t  q;
    bit      typed;
    answer_t ans;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LIMIT_W-1:0] zero_length_limit = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] kind = KIND_3D;
  logic signed [FIELD_W-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic signed [FIELD_W-1:0] first_x = '0, first_y = '0, first_z = '0;
  logic signed [FIELD_W-1:0] second_x = '0, second_y = '0, second_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DIST_W-1:0] distance;
  logic [1:0] region;

  point_segment_distance_top u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .zero_length_limit(zero_length_limit),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .first_x(first_x), .first_y(first_y), .first_z(first_z),
    .second_x(second_x), .second_y(second_y), .second_z(second_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .distance(distance), .region(region)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  answer_t pending_answers [$];
  logic [LIMIT_W-1:0] cur_limit = LIMIT_RESET;
  int err_count = 0;
  int cycle_count = 0;
  bit quiet = 1'b0;
  bit long_hold = 1'b0;
  bit send_gaps = 1'b1;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    err_count++;
  endtask

  // axis used by a lane for a given projection
  function automatic int lane_axis(input logic [1:0] k, input int lane);
    case (k)
      KIND_3D: lane_axis = lane;
      KIND_XY: lane_axis = lane;
      KIND_YZ: lane_axis = lane + 1;
      default: lane_axis = (lane == 0) ? 2 : 0;
    endcase
  endfunction

  function automatic logic [63:0] floor_root(input logic [127:0] n);
    logic [63:0] res;
    logic [63:0] c;
    res = '0;
    for (int bitn = 63; bitn >= 0; bitn--) begin
      c = res | (64'd1 << bitn);
      if ({64'd0, c} * {64'd0, c} <= n) res = c;
    end
    floor_root = res;
  endfunction

  function automatic logic [DIST_W-1:0] sat_root(input logic [127:0] n);
    logic [63:0] r;
    r = floor_root(n);
    sat_root = (r > 64'hFFFF_FFFF) ? '1 : r[DIST_W-1:0];
  endfunction

  function automatic answer_t segment_distance(input query_t q, input logic [LIMIT_W-1:0] lim);
    answer_t ans;
    int nl;
    int ax;
    logic signed [33:0] d;
    logic [127:0] am [3], bm [3], cm [3], em [3];
    bit an [3], bn [3];
    logic [127:0] len2, pos, negs, lim2, dm, uq, off, sa, sc;
    nl = (q.kind == KIND_3D) ? 3 : 2;
    len2 = '0; pos = '0; negs = '0; sa = '0; sc = '0;
    for (int i = 0; i < nl; i++) begin
      ax = lane_axis(q.kind, i);
      d = 34'(q.pt[ax]) - 34'(q.fa[ax]);
      an[i] = d < 0; am[i] = 128'(an[i] ? -d : d);
      d = 34'(q.sb[ax]) - 34'(q.fa[ax]);
      bn[i] = d < 0; bm[i] = 128'(bn[i] ? -d : d);
      d = 34'(q.pt[ax]) - 34'(q.sb[ax]);
      cm[i] = 128'(d < 0 ? -d : d);
      len2 += bm[i] * bm[i];
      sa += am[i] * am[i];
      sc += cm[i] * cm[i];
      if (an[i] != bn[i]) negs += am[i] * bm[i];
      else pos += am[i] * bm[i];
    end
    lim2 = 128'(lim) * 128'(lim);
    if (len2 == 0 || len2 < lim2) begin
      ans.reg_code = REGION_DEGEN; ans.dist_raw = sat_root(sa);
    end else if (negs > pos) begin
      ans.reg_code = REGION_BEFORE; ans.dist_raw = sat_root(sa);
    end else begin
      dm = pos - negs;
      if (dm > len2) begin
        ans.reg_code = REGION_PAST; ans.dist_raw = sat_root(sc);
      end else begin
        uq = (dm << 32) / len2;
        sa = '0;
        for (int i = 0; i < nl; i++) begin
          off = (uq * bm[i] + 128'h8000_0000) >> 32;
          if (an[i] != bn[i]) em[i] = am[i] + off;
          else em[i] = (am[i] >= off) ? am[i] - off : off - am[i];
          sa += em[i] * em[i];
        end
        ans.reg_code = REGION_INTERIOR; ans.dist_raw = sat_root(sa);
      end
    end
    segment_distance = ans;
  endfunction

  task automatic write_limit(input logic [LIMIT_W-1:0] val);
    cfg_valid <= 1'b1;
    zero_length_limit <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_limit = val;
  endtask

  function automatic int short_or_long_gap();
    if ($urandom_range(0, 9) == 0) short_or_long_gap = $urandom_range(10, 40);
    else short_or_long_gap = $urandom_range(1, 3);
  endfunction

  task automatic send_query(input row_t r);
    int gap;
    in_valid <= 1'b1;
    kind <= r.q.kind;
    point_x <= r.q.pt[0]; point_y <= r.q.pt[1]; point_z <= r.q.pt[2];
    first_x <= r.q.fa[0]; first_y <= r.q.fa[1]; first_z <= r.q.fa[2];
    second_x <= r.q.sb[0]; second_y <= r.q.sb[1]; second_z <= r.q.sb[2];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_answers.push_back(r.typed ? r.ans : segment_distance(r.q, cur_limit));
    if (send_gaps && !quiet && $urandom_range(0, 3) == 0) begin
      gap = short_or_long_gap();
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  function automatic row_t make_row(input logic [1:0] k,
      input logic signed [31:0] px, py, pz, ax, ay, az, bx, by, bz,
      input bit typed, input logic [31:0] d, input logic [1:0] rc);
    row_t r;
    r.q.kind = k;
    r.q.pt = '{px, py, pz}; r.q.fa = '{ax, ay, az}; r.q.sb = '{bx, by, bz};
    r.typed = typed; r.ans.dist_raw = d; r.ans.reg_code = rc;
    make_row = r;
  endfunction

  function automatic logic signed [31:0] near_val(input int base, input int span);
    near_val = base + int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic row_t random_row();
    row_t r;
    int mode, span;
    int base [3];
    mode = $urandom_range(0, 9);
    r.typed = 1'b0;
    r.q.kind = 2'($urandom_range(0, 3));
    span = ($urandom_range(0, 3) == 0) ? (1 << 24) : (1 << 18);
    for (int i = 0; i < 3; i++) base[i] = near_val(0, 1 << 28);
    for (int i = 0; i < 3; i++) begin
      if (mode < 2) begin
        r.q.pt[i] = $urandom; r.q.fa[i] = $urandom; r.q.sb[i] = $urandom;
      end else begin
        r.q.fa[i] = near_val(base[i], span);
        r.q.sb[i] = (mode == 9) ? near_val(r.q.fa[i], 1 << $urandom_range(0, 16))
                                : near_val(r.q.fa[i], span);
        // points along the segment to hit the interior more often
        r.q.pt[i] = (mode >= 7) ? r.q.fa[i] + (r.q.sb[i] - r.q.fa[i]) / 2
                                  + near_val(0, 1 << 10)
                                : near_val(base[i], span);
      end
    end
    random_row = r;
  endfunction

  row_t dir_table [$];

  initial begin
    logic signed [31:0] mx, mn, one;
    logic [LIMIT_W-1:0] limits [5];
    mx = 32'sh7FFF_FFFF; mn = 32'sh8000_0000; one = 32'sd65536;
    limits = '{17'd0, 17'd65536, 17'h1FFFF, 17'd1, 17'd300};
    dir_table.push_back(make_row(KIND_3D, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, REGION_DEGEN));
    dir_table.push_back(make_row(KIND_3D, mx, mx, mx, mn, mn, mn, mn, mn, mn,
                                 1, 32'hFFFF_FFFF, REGION_DEGEN));
    dir_table.push_back(make_row(KIND_XY, -one, 0, 0, 0, 0, 0, one, 0, 0, 1, one, REGION_BEFORE));
    dir_table.push_back(make_row(KIND_3D, 2 * one, 0, 0, 0, 0, 0, one, 0, 0, 1, one, REGION_PAST));
    dir_table.push_back(make_row(KIND_3D, one / 2, one, 0, 0, 0, 0, one, 0, 0,
                                 1, one, REGION_INTERIOR));
    dir_table.push_back(make_row(KIND_YZ, 5, 0, one, 5, 0, 0, 9, 0, 2 * one,
                                 1, 0, REGION_INTERIOR));
    dir_table.push_back(make_row(KIND_ZX, 0, 7, 0, 0, 0, 0, 0, 3, one, 1, 0, REGION_INTERIOR));
    dir_table.push_back(make_row(KIND_3D, 0, 0, 0, 0, 0, 0, one, one, one, 0, 0, 0));
    dir_table.push_back(make_row(KIND_3D, one, one, one, 0, 0, 0, one, one, one, 0, 0, 0));
    dir_table.push_back(make_row(KIND_XY, mx, mn, mx, mn, mx, mn, mx, mx, mx, 0, 0, 0));
    dir_table.push_back(make_row(KIND_YZ, mn, mx, mn, mx, mn, mx, mn, mn, mn, 0, 0, 0));
    dir_table.push_back(make_row(KIND_ZX, mx, mx, mn, 0, 0, 0, -1, -1, -1, 0, 0, 0));
    dir_table.push_back(make_row(KIND_3D, 3, 4, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    dir_table.push_back(make_row(KIND_XY, -one, -one, 0, one, one, 0, -one, one, 0, 0, 0, 0));
    dir_table.push_back(make_row(KIND_3D, 12345, -999, 77, 1, 2, 3, -1, -2, -3, 0, 0, 0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_limit(LIMIT_RESET);
    foreach (dir_table[i]) send_query(dir_table[i]);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      write_limit(limits[ph]);
      quiet = (ph == 3);
      for (int n = 0; n < 150; n++) begin
        if (ph == 1 && n == 40) begin
          send_gaps = 1'b0;
          long_hold = 1'b1;
        end
        if (ph == 1 && n == 120) send_gaps = 1'b1;
        if (ph == 2 && n == 75) drain();
        send_query(random_row());
      end
      drain();
    end
    write_limit(17'($urandom));
    for (int n = 0; n < 20; n++) send_query(random_row());
    drain();
    if (err_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // output side: random stalls plus one long hold-off
  initial begin
    int len;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        len = short_or_long_gap();
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected transfer", distance, 0);
      end else begin
        want = pending_answers.pop_front();
        if (distance !== want.dist_raw) report_mismatch("distance", distance, want.dist_raw);
        if (region !== want.reg_code) report_mismatch("region", region, want.reg_code);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
